>>> src/energy_voice_activity_detector_unit_assert.svh
// Assertion macros shared by the detector RTL.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_UNIT_ASSERT_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define EVAD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define EVAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EVAD_ASSERT(label, ante, cons)
`define EVAD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/evad_pkg.sv
package evad_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int MAX_VOTE_FRAMES   = 32;
    localparam int COUNT_W           = 13;
    localparam int ENERGY_W          = 43;
    localparam int TIME_W            = 32;
    localparam int THR_W             = 15;
    localparam int RATIO_W           = 16;
    localparam int HANG_W            = 16;
    localparam int VOTE_W            = 6;
    localparam int POS_W             = $clog2(MAX_VOTE_FRAMES);
    localparam int GROUP_BITS        = 8;
    localparam int RING_GROUPS       = MAX_VOTE_FRAMES / GROUP_BITS;
    localparam int PART_W            = $clog2(GROUP_BITS + 1);
    localparam int SQ_W              = 2 * SAMPLE_BITS;
    localparam int CFG_IDX_W         = 4;
    localparam int CFG_DATA_W        = 16;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENERGY_THR = 4'd0,
        CFG_RATIO_THR  = 4'd1,
        CFG_HANGOVER   = 4'd2,
        CFG_VOTE_FRAMES = 4'd3
    } t_cfg_reg;

    // Totals of one finished frame, handed from the front end to the decision stages.
    typedef struct packed {
        logic [COUNT_W-1:0]  loud_count;
        logic [ENERGY_W-1:0] energy_sum;
        logic [COUNT_W-1:0]  frame_length;
        logic [TIME_W-1:0]   time_ms;
    } t_frame;

    // Clamp the vote ring size to 1..MAX_VOTE_FRAMES.
    function automatic logic [VOTE_W-1:0] eff_votes(input logic [VOTE_W-1:0] vf);
        logic [VOTE_W-1:0] res;
        if (vf == '0) begin
            res = VOTE_W'(1);
        end else if (vf > VOTE_W'(MAX_VOTE_FRAMES)) begin
            res = VOTE_W'(MAX_VOTE_FRAMES);
        end else begin
            res = vf;
        end
        return res;
    endfunction

endpackage

>>> src/energy_voice_activity_detector_unit.sv
// Energy voice activity detector.
// Input channel: one signed sample per item with a frame-end mark and a ms
// timestamp, handshaked by i_in_valid / o_in_stall. Only a frame-end item
// produces a result on the output channel (o_out_valid / i_out_stall):
// smoothed speech decision, raw frame decision, vote count and the echoed time.
// Configuration: registers 0..3 written through i_cfg_valid / o_cfg_ready
// with an index and data; o_cfg_ready is always high, unknown indexes drop.
// Throughput: one item per cycle while o_in_stall is low. A frame-end item,
// once accepted, passes through the input register, then square, frame totals,
// threshold products, compare and vote ring follow, and the hangover decision
// lands in the output register that drives o_out_valid; the 16x16 sample
// squarer and the threshold-times-length products each own a stage.
// Reset clears the frame totals, vote ring, hangover state and pipeline, and
// loads register defaults. When the receiver stalls the result holds; the
// pipeline keeps taking samples until a frame-end item would have to
// overtake a blocked stage, then o_in_stall rises.
module energy_voice_activity_detector_unit
    import evad_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_frame_end,
    input  logic [TIME_W-1:0]             i_time_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_speech_active,
    output logic                          o_frame_detect,
    output logic [VOTE_W-1:0]             o_vote_count,
    output logic [TIME_W-1:0]             o_frame_time_ms,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    `include "energy_voice_activity_detector_unit_assert.svh"

    // configuration
    logic [THR_W-1:0]   r_eth;
    logic [RATIO_W-1:0] r_ratio;
    logic [HANG_W-1:0]  r_hang;
    logic [VOTE_W-1:0]  r_votes;
    logic [SQ_W-1:0]    r_thr_sq;

    // stage 3: frame totals
    logic               r_s3_v;
    t_frame             r_s3;

    // stage 4: products
    logic                        r_s4_v;
    logic [COUNT_W-1:0]          r_s4_loud;
    logic [ENERGY_W-1:0]         r_s4_sum;
    logic [COUNT_W+RATIO_W-1:0]  r_s4_ratio_prod;
    logic [SQ_W+COUNT_W-1:0]     r_s4_rms_prod;
    logic [TIME_W-1:0]           r_s4_time;

    // stage 5: ring partial counts
    logic                           r_s5_v;
    logic [RING_GROUPS-1:0][PART_W-1:0] r_s5_part;
    logic                           r_s5_detect;
    logic [TIME_W-1:0]              r_s5_time;

    // vote ring and hangover state
    logic [MAX_VOTE_FRAMES-1:0] r_ring;
    logic [POS_W-1:0]           r_pos;
    logic                       r_flag;
    logic [TIME_W-1:0]          r_last;

    // output register
    logic                r_out_v;
    logic                r_out_speech;
    logic                r_out_detect;
    logic [VOTE_W-1:0]   r_out_count;
    logic [TIME_W-1:0]   r_out_time;

    logic                front_v;
    t_frame              front_frame;
    logic                out_free;
    logic                s5_go;
    logic                s5_free;
    logic                s4_go;
    logic                s4_free;
    logic                s3_go;
    logic                s3_free;
    logic [VOTE_W-1:0]   neff;
    logic [THR_W:0]      thr2;
    logic                detect;
    logic [POS_W-1:0]    wr_pos;
    logic [VOTE_W-1:0]   pos_inc;
    logic [POS_W-1:0]    n_pos;
    logic [MAX_VOTE_FRAMES-1:0] n_ring;
    logic [RING_GROUPS-1:0][PART_W-1:0] n_part;
    logic [VOTE_W-1:0]   count;
    logic                vote;
    logic                n_flag;
    logic [TIME_W-1:0]   n_last;
    logic [TIME_W-1:0]   elapsed;

    evad_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_sample           (i_sample),
        .i_frame_end        (i_frame_end),
        .i_time_ms          (i_time_ms),
        .i_energy_threshold (r_eth),
        .o_valid            (front_v),
        .i_stall            (!s3_free),
        .o_frame            (front_frame)
    );

    assign out_free = !r_out_v || !i_out_stall;
    assign s5_go    = r_s5_v && out_free;
    assign s5_free  = !r_s5_v || s5_go;
    assign s4_go    = r_s4_v && s5_free;
    assign s4_free  = !r_s4_v || s4_go;
    assign s3_go    = r_s3_v && s4_free;
    assign s3_free  = !r_s3_v || s3_go;

    assign neff        = eff_votes(r_votes);
    assign thr2        = {r_eth, 1'b0};
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eth   <= THR_W'(328);
            r_ratio <= RATIO_W'(6554);
            r_hang  <= HANG_W'(300);
            r_votes <= VOTE_W'(5);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENERGY_THR:  r_eth   <= i_cfg_data[THR_W-1:0];
                CFG_RATIO_THR:   r_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_HANGOVER:    r_hang  <= i_cfg_data[HANG_W-1:0];
                CFG_VOTE_FRAMES: r_votes <= i_cfg_data[VOTE_W-1:0];
                default: ;
            endcase
        end
    end

    // (2 * threshold)^2, registered; read when stage 4 loads from stage 3
    always_ff @(posedge i_clk) begin
        r_thr_sq <= SQ_W'(thr2) * SQ_W'(thr2);
    end

    // stage 4: threshold tests, ring write position
    always_comb begin
        detect = ({r_s4_loud, {RATIO_W{1'b0}}} > r_s4_ratio_prod)
              || ((SQ_W + COUNT_W)'(r_s4_sum) > r_s4_rms_prod);
        wr_pos  = (VOTE_W'(r_pos) >= neff) ? '0 : r_pos;
        pos_inc = VOTE_W'(wr_pos) + 1'b1;
        n_pos   = (pos_inc >= neff) ? '0 : pos_inc[POS_W-1:0];
        n_ring  = r_ring;
        n_ring[wr_pos] = detect;
        for (int g = 0; g < RING_GROUPS; g++) begin
            n_part[g] = '0;
            for (int b = 0; b < GROUP_BITS; b++) begin
                if (VOTE_W'(g * GROUP_BITS + b) < neff) begin
                    n_part[g] = n_part[g] + PART_W'(n_ring[g * GROUP_BITS + b]);
                end
            end
        end
    end

    // stage 5: majority vote and hangover
    always_comb begin
        count = '0;
        for (int g = 0; g < RING_GROUPS; g++) begin
            count = count + VOTE_W'(r_s5_part[g]);
        end
        vote    = count > (neff >> 1);
        elapsed = r_s5_time - r_last;
        n_flag  = r_flag;
        n_last  = r_last;
        if (vote) begin
            n_flag = 1'b1;
            n_last = r_s5_time;
        end else if (r_flag && elapsed > TIME_W'(r_hang)) begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_ring  <= '0;
            r_pos   <= '0;
            r_flag  <= 1'b0;
            r_last  <= '0;
        end else begin
            if (s3_free) begin
                r_s3_v <= front_v;
            end
            if (s4_free) begin
                r_s4_v <= s3_go;
            end
            if (s5_free) begin
                r_s5_v <= s4_go;
            end
            if (out_free) begin
                r_out_v <= s5_go;
            end
            if (s4_go) begin
                r_ring <= n_ring;
                r_pos  <= n_pos;
            end
            if (s5_go) begin
                r_flag <= n_flag;
                r_last <= n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_s3 <= front_frame;
        end
        if (s4_free) begin
            r_s4_loud       <= r_s3.loud_count;
            r_s4_sum        <= r_s3.energy_sum;
            r_s4_ratio_prod <= (COUNT_W + RATIO_W)'(r_ratio)
                             * (COUNT_W + RATIO_W)'(r_s3.frame_length);
            r_s4_rms_prod   <= (SQ_W + COUNT_W)'(r_thr_sq)
                             * (SQ_W + COUNT_W)'(r_s3.frame_length);
            r_s4_time       <= r_s3.time_ms;
        end
        if (s5_free) begin
            r_s5_part   <= n_part;
            r_s5_detect <= detect;
            r_s5_time   <= r_s4_time;
        end
        if (out_free) begin
            r_out_speech <= n_flag;
            r_out_detect <= r_s5_detect;
            r_out_count  <= count;
            r_out_time   <= r_s5_time;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_speech_active = r_out_speech;
    assign o_frame_detect  = r_out_detect;
    assign o_vote_count    = r_out_count;
    assign o_frame_time_ms = r_out_time;

    `EVAD_ASSERT(a_count_le_size, r_s5_v, count <= neff)
    `EVAD_ASSERT(a_vote_means_speech, r_out_v && (r_out_count > (neff >> 1)), r_out_speech)

endmodule

>>> src/evad_front.sv
module evad_front
    import evad_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_frame_end,
    input  logic [TIME_W-1:0]             i_time_ms,
    input  logic [THR_W-1:0]              i_energy_threshold,
    output logic                          o_valid,
    input  logic                          i_stall,
    output t_frame                        o_frame
);

    `include "energy_voice_activity_detector_unit_assert.svh"

    // stage 1: input register
    logic                          r_s1_v;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic                          r_s1_fe;
    logic [TIME_W-1:0]             r_s1_time;

    // stage 2: square and loud flag
    logic                   r_s2_v;
    logic [SQ_W-1:0]        r_s2_sq;
    logic                   r_s2_loud;
    logic                   r_s2_fe;
    logic [TIME_W-1:0]      r_s2_time;

    // frame accumulators
    logic [COUNT_W-1:0]     r_loud;
    logic [ENERGY_W-1:0]    r_sum;
    logic [COUNT_W-1:0]     r_len;

    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        sq;
    logic                   s1_go;
    logic                   s1_free;
    logic                   s2_go;
    logic                   s2_free;
    logic [COUNT_W-1:0]     n_loud;
    logic [ENERGY_W-1:0]    n_sum;
    logic [COUNT_W-1:0]     n_len;
    logic [ENERGY_W:0]      sum_wide;

    assign s2_go   = r_s2_v && (!r_s2_fe || !i_stall);
    assign s2_free = !r_s2_v || s2_go;
    assign s1_go   = r_s1_v && s2_free;
    assign s1_free = !r_s1_v || s1_go;
    assign o_stall = !s1_free;

    // Magnitude of the most negative code is its unsigned complement.
    assign mag = r_s1_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_s1_sample)
                                            : SAMPLE_BITS'(r_s1_sample);
    assign sq  = SQ_W'(mag) * SQ_W'(mag);

    always_comb begin
        sum_wide = {1'b0, r_sum} + (ENERGY_W + 1)'(r_s2_sq);
        n_sum    = sum_wide[ENERGY_W] ? ENERGY_MAX : sum_wide[ENERGY_W-1:0];
        n_loud   = (r_s2_loud && r_loud != COUNT_MAX) ? r_loud + 1'b1 : r_loud;
        n_len    = (r_len != COUNT_MAX) ? r_len + 1'b1 : r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_loud <= '0;
            r_sum  <= '0;
            r_len  <= '0;
        end else begin
            if (s1_free) begin
                r_s1_v <= i_valid;
            end
            if (s2_free) begin
                r_s2_v <= s1_go;
            end
            if (s2_go) begin
                if (r_s2_fe) begin
                    r_loud <= '0;
                    r_sum  <= '0;
                    r_len  <= '0;
                end else begin
                    r_loud <= n_loud;
                    r_sum  <= n_sum;
                    r_len  <= n_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_sample <= i_sample;
            r_s1_fe     <= i_frame_end;
            r_s1_time   <= i_time_ms;
        end
        if (s2_free) begin
            r_s2_sq   <= sq;
            r_s2_loud <= mag > SAMPLE_BITS'(i_energy_threshold);
            r_s2_fe   <= r_s1_fe;
            r_s2_time <= r_s1_time;
        end
    end

    assign o_valid               = r_s2_v && r_s2_fe;
    assign o_frame.loud_count    = n_loud;
    assign o_frame.energy_sum    = n_sum;
    assign o_frame.frame_length  = n_len;
    assign o_frame.time_ms       = r_s2_time;

    `EVAD_ASSERT(a_loud_le_len, 1'b1, r_loud <= r_len)
    `EVAD_ASSERT(a_s1_moves_when_s2_empty, r_s1_v && !r_s2_v, s1_go)

endmodule

>>> tb/sv/evad_frame_checker.sv
module evad_frame_checker
    import evad_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_frame_end,
    input  logic [TIME_W-1:0]             i_time_ms,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_speech_active,
    input  logic                          i_frame_detect,
    input  logic [VOTE_W-1:0]             i_vote_count,
    input  logic [TIME_W-1:0]             i_frame_time_ms,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic              speech;
        logic              detect;
        logic [VOTE_W-1:0] votes;
        logic [TIME_W-1:0] stamp;
    } t_frame_verdict;

    t_frame_verdict verdict_q[$];

    logic [THR_W-1:0]           thr_reg;
    logic [RATIO_W-1:0]         ratio_reg;
    logic [HANG_W-1:0]          hang_reg;
    logic [VOTE_W-1:0]          votes_reg;

    logic [COUNT_W-1:0]         loud_cnt;
    logic [ENERGY_W-1:0]        energy_acc;
    logic [COUNT_W-1:0]         frame_len;
    logic [MAX_VOTE_FRAMES-1:0] vote_bits;
    int                         ring_pos;
    logic                       speech_hold;
    logic [TIME_W-1:0]          last_speech;
    int                         fail_cnt = 0;

    function automatic void flag_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    // Fold one sample into the running frame; on a frame end, decide and queue the verdict.
    function automatic void feed_sample(input logic [SAMPLE_BITS-1:0] raw, input logic fe,
                                        input logic [TIME_W-1:0] now);
        logic [SAMPLE_BITS:0] mag;
        logic [63:0]          sq;
        logic [63:0]          twice_thr;
        logic                 detect;
        int                   n;
        int                   cnt;
        t_frame_verdict       v;

        mag = raw[SAMPLE_BITS-1] ? {1'b0, ~raw} + 1'b1 : {1'b0, raw};
        sq = 64'(mag) * 64'(mag);
        if (mag > {1'b0, thr_reg} && loud_cnt != '1) begin
            loud_cnt++;
        end
        if (64'(energy_acc) + sq > 64'(ENERGY_MAX)) begin
            energy_acc = '1;
        end else begin
            energy_acc = energy_acc + ENERGY_W'(sq);
        end
        if (frame_len != '1) begin
            frame_len++;
        end
        if (!fe) begin
            return;
        end

        twice_thr = 64'(thr_reg) * 2;
        detect = ((64'(loud_cnt) << 16) > 64'(ratio_reg) * 64'(frame_len))
                 || (64'(energy_acc) > twice_thr * twice_thr * 64'(frame_len));

        if (votes_reg == '0) begin
            n = 1;
        end else if (int'(votes_reg) > MAX_VOTE_FRAMES) begin
            n = MAX_VOTE_FRAMES;
        end else begin
            n = int'(votes_reg);
        end
        // A shrunk ring keeps its bits; only the write position wraps.
        if (ring_pos >= n) begin
            ring_pos = 0;
        end
        vote_bits[ring_pos] = detect;
        ring_pos++;
        if (ring_pos >= n) begin
            ring_pos = 0;
        end
        cnt = 0;
        for (int i = 0; i < n; i++) begin
            cnt += vote_bits[i];
        end

        if (cnt > n / 2) begin
            speech_hold = 1'b1;
            last_speech = now;
        end else if (speech_hold && TIME_W'(now - last_speech) > TIME_W'(hang_reg)) begin
            speech_hold = 1'b0;
        end

        loud_cnt = '0;
        energy_acc = '0;
        frame_len = '0;

        v.speech = speech_hold;
        v.detect = detect;
        v.votes = VOTE_W'(cnt);
        v.stamp = now;
        verdict_q.push_back(v);
    endfunction

    always @(posedge i_clk) begin
        t_frame_verdict want;
        if (!i_rst_n) begin
            thr_reg = 15'd328;
            ratio_reg = 16'd6554;
            hang_reg = 16'd300;
            votes_reg = 6'd5;
            loud_cnt = '0;
            energy_acc = '0;
            frame_len = '0;
            vote_bits = '0;
            ring_pos = 0;
            speech_hold = 1'b0;
            last_speech = '0;
            verdict_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    flag_failure($sformatf("result with nothing expected: speech %0b detect %0b votes %0d time %0h",
                                           i_speech_active, i_frame_detect, i_vote_count,
                                           i_frame_time_ms));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_speech_active !== want.speech || i_frame_detect !== want.detect
                        || i_vote_count !== want.votes || i_frame_time_ms !== want.stamp) begin
                        flag_failure($sformatf({"verdict mismatch (expected/actual): speech %0b/%0b",
                                                " detect %0b/%0b votes %0d/%0d time %0h/%0h"},
                                               want.speech, i_speech_active,
                                               want.detect, i_frame_detect,
                                               want.votes, i_vote_count,
                                               want.stamp, i_frame_time_ms));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_ENERGY_THR: begin
                        thr_reg = i_cfg_data[THR_W-1:0];
                    end
                    CFG_RATIO_THR: begin
                        ratio_reg = i_cfg_data[RATIO_W-1:0];
                    end
                    CFG_HANGOVER: begin
                        hang_reg = i_cfg_data[HANG_W-1:0];
                    end
                    CFG_VOTE_FRAMES: begin
                        votes_reg = i_cfg_data[VOTE_W-1:0];
                    end
                    default: begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                feed_sample(i_sample, i_frame_end, i_time_ms);
            end
        end
        o_mismatches <= fail_cnt;
        o_pending <= verdict_q.size();
    end

endmodule

>>> tb/sv/tb.sv
module tb
    import evad_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PHASES         = 10;
    localparam int ITEMS_PER_PHASE  = 188;
    localparam int PRESSURE_PHASE   = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 12;
    localparam int TIMEOUT_NS       = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] LAST_CFG_IDX = '1;

    typedef enum {FRAME_QUIET, FRAME_LOUD} t_frame_kind;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          frame_end;
    logic [TIME_W-1:0]             time_ms;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          speech_active;
    logic                          frame_detect;
    logic [VOTE_W-1:0]             vote_count;
    logic [TIME_W-1:0]             frame_time_ms;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    int                            mismatches;
    int                            pending;

    int                            send_idle_pct = 0;
    int                            stall_pct = 0;
    bit                            long_hold_req = 1'b0;
    int                            cur_thr = 328;
    logic [TIME_W-1:0]             now_ms = '0;
    bit                            talking = 1'b0;

    energy_voice_activity_detector_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_sample        (in_sample),
        .i_frame_end     (frame_end),
        .i_time_ms       (time_ms),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_speech_active (speech_active),
        .o_frame_detect  (frame_detect),
        .o_vote_count    (vote_count),
        .o_frame_time_ms (frame_time_ms),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    evad_frame_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_sample        (in_sample),
        .i_frame_end     (frame_end),
        .i_time_ms       (time_ms),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_speech_active (speech_active),
        .i_frame_detect  (frame_detect),
        .i_vote_count    (vote_count),
        .i_frame_time_ms (frame_time_ms),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back the pipeline up.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s, input logic fe,
                             input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_sample <= s;
        frame_end <= fe;
        time_ms <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input int len, input t_frame_kind kind);
        int                            m;
        logic signed [SAMPLE_BITS-1:0] s;
        for (int k = 0; k < len; k++) begin
            case (kind)
                FRAME_QUIET: begin
                    m = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32768)
                                                    : $urandom_range(0, cur_thr);
                end
                default: begin
                    m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32768)
                                                    : $urandom_range(cur_thr, 32768);
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                s = SAMPLE_BITS'(-m);
            end else begin
                s = SAMPLE_BITS'((m > 32767) ? 32767 : m);
            end
            send_item(s, k == len - 1, (k == len - 1) ? now_ms : TIME_W'($urandom()));
        end
    endtask

    // Hold the input idle until every verdict is back and the pipeline has emptied.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] ratio;
        logic [CFG_DATA_W-1:0] hang;
        logic [CFG_DATA_W-1:0] votes;
        int                    budget;
        int                    len;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_sample = '0;
        frame_end = 1'b0;
        time_ms = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset settings: field extremes, threshold edges,
        // one-sample frames, a talk spurt, hangover expiry and a time wrap.
        send_item(16'sd0, 1'b0, 32'h0);
        send_item(16'sd32767, 1'b0, 32'h0);
        send_item(16'sh8000, 1'b0, 32'h0);
        send_item(16'sd328, 1'b0, 32'h0);
        send_item(16'sd329, 1'b0, 32'h0);
        send_item(-16'sd329, 1'b0, 32'h0);
        send_item(-16'sd1, 1'b1, 32'h0);
        send_item(16'sh8000, 1'b1, 32'hFFFF_FFFF);
        send_item(16'sd0, 1'b1, 32'd100);
        send_item(16'sd328, 1'b1, 32'd110);
        send_item(16'sd329, 1'b1, 32'd200);
        send_item(-16'sd20000, 1'b1, 32'd210);
        send_item(16'sd20000, 1'b1, 32'd220);
        send_item(16'sd0, 1'b1, 32'd300);
        send_item(16'sd5, 1'b0, 32'h0);
        send_item(-16'sd5, 1'b1, 32'd400);
        send_item(16'sd0, 1'b1, 32'd520);
        send_item(16'sd0, 1'b1, 32'd521);
        send_item(16'sd0, 1'b1, 32'd900);
        send_item(16'sd1, 1'b1, 32'd10);
        wait_idle();

        now_ms = 32'hFFFF_F000;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    thr = '0;
                    ratio = '0;
                    hang = '0;
                    votes = 16'd1;
                end
                1: begin
                    thr = '1;
                    ratio = '1;
                    hang = '1;
                    votes = 16'd32;
                end
                2: begin
                    thr = CFG_DATA_W'($urandom_range(0, 2000));
                    ratio = CFG_DATA_W'($urandom());
                    hang = CFG_DATA_W'($urandom_range(0, 800));
                    votes = '0;
                end
                3: begin
                    thr = CFG_DATA_W'($urandom_range(0, 2000));
                    ratio = CFG_DATA_W'($urandom());
                    hang = CFG_DATA_W'($urandom_range(0, 800));
                    votes = '1;
                end
                default: begin
                    thr = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom())
                                                      : CFG_DATA_W'($urandom_range(0, 4000));
                    ratio = CFG_DATA_W'($urandom());
                    hang = CFG_DATA_W'($urandom_range(0, 800));
                    votes = CFG_DATA_W'($urandom_range(0, 40));
                end
            endcase
            cfg_write(CFG_ENERGY_THR, thr);
            cfg_write(CFG_RATIO_THR, ratio);
            cfg_write(CFG_HANGOVER, hang);
            cfg_write(CFG_VOTE_FRAMES, votes);
            cfg_write(CFG_IDX_W'($urandom_range(CFG_VOTE_FRAMES + 1, LAST_CFG_IDX)),
                      CFG_DATA_W'($urandom()));
            cfg_valid <= 1'b0;
            cur_thr = int'(thr[THR_W-1:0]);

            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 63;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 63;
                end
                default: begin
                    send_idle_pct = 11;
                    stall_pct = 11;
                end
            endcase
            if (ph == PRESSURE_PHASE) begin
                long_hold_req = 1'b1;
            end

            budget = 0;
            while (budget < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 5) == 0) begin
                    talking = !talking;
                end
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
                if ($urandom_range(0, 19) == 0) begin
                    now_ms = TIME_W'($urandom());
                end else begin
                    now_ms += TIME_W'($urandom_range(0, 80));
                end
                send_frame(len, (talking ^ ($urandom_range(0, 4) == 0)) ? FRAME_LOUD : FRAME_QUIET);
                budget += len;
            end
            wait_idle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
